[hdl/flash_segment_smart_writer_defines.svh]
// assertion macros for the flash segment writer
`ifndef FLASH_SEGMENT_SMART_WRITER_DEFINES_SVH
`define FLASH_SEGMENT_SMART_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
`define FSSW_ASSERT_IMPLIES(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define FSSW_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define FSSW_ASSERT_IMPLIES(lbl, a, b)
`define FSSW_ASSERT_NEXT(lbl, a, b)
`endif
`endif

[hdl/fssw_pkg.sv]
// shared types and constants for the flash segment writer
`default_nettype none
package fssw_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int SEG_MAX_DEF   = 512;
    localparam int CFG_SIZE_W    = 10;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_DATA  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_MEM   = 2'd1;
    localparam logic [1:0] ST_ZERO_LEN = 2'd2;
    localparam logic [1:0] ST_VERIFY   = 2'd3;

    localparam logic [2:0] REG_INFO_LOW  = 3'd0;
    localparam logic [2:0] REG_INFO_HIGH = 3'd1;
    localparam logic [2:0] REG_MAIN_LOW  = 3'd2;
    localparam logic [2:0] REG_MAIN_HIGH = 3'd3;
    localparam logic [2:0] REG_INFO_SEG  = 3'd4;
    localparam logic [2:0] REG_MAIN_SEG  = 3'd5;

    localparam logic [15:0] INFO_LOW_RST  = 16'd6144;
    localparam logic [15:0] INFO_HIGH_RST = 16'd6655;
    localparam logic [15:0] MAIN_LOW_RST  = 16'd32768;
    localparam logic [15:0] MAIN_HIGH_RST = 16'd65535;
    localparam logic [CFG_SIZE_W-1:0] INFO_SEG_RST = 10'd128;
    localparam logic [CFG_SIZE_W-1:0] MAIN_SEG_RST = 10'd512;

    typedef struct packed {
        logic       clr_step;
        logic       acc_start;
        logic       div_step;
        logic       start_fin;
        logic       acc_data;
        logic       acc_read;
        logic       next_seg;
        logic       clr_active;
        logic       walk_first;
        logic       walk_zero;
        logic       i_inc;
        logic       mem_rd;
        logic       act_scan;
        logic       act_copy;
        logic       act_rewrite;
        logic       act_prog;
        logic       act_verify;
        logic       emit;
        logic       emit_read;
        logic [1:0] emit_status;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic len_zero;
        logic region_none;
        logic div_done;
        logic write_active;
        logic commit_now;
        logic piece_last;
        logic i_done;
        logic need_erase;
        logic verify_fail;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

[hdl/fssw_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module fssw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[hdl/fssw_datapath.sv]
// datapath: config registers, divider, pointers, store and segment buffer
`default_nettype none
module fssw_datapath #(
    parameter int ADDR_BITS = 16,
    parameter int SEG_MAX   = 512
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic [15:0]          address,
    input  wire logic [15:0]          length,
    input  wire logic [7:0]           data_byte,
    input  wire fssw_pkg::cmd_t       cmd,
    output fssw_pkg::stat_t           stat,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic                      reply_kind,
    output logic [1:0]                status,
    output logic [7:0]                read_data
);
    import fssw_pkg::*;

    localparam int SW = $clog2(SEG_MAX + 1);
    localparam int BW = $clog2(SEG_MAX);
    localparam int RW = SW + 1;
    localparam logic [31:0] SEG_MAX_W = 32'(SEG_MAX);
    localparam int STORE_DEPTH = 1 << ADDR_BITS;

    function automatic logic [SW-1:0] eff_size(input logic [CFG_SIZE_W-1:0] s);
        logic [31:0] w;
        begin
            w = 32'(s);
            if (w == 32'd0)
                return SW'(1);
            else if (w > SEG_MAX_W)
                return SW'(SEG_MAX);
            else
                return SW'(w);
        end
    endfunction

    logic [15:0] info_low_reg, info_high_reg, main_low_reg, main_high_reg;
    logic [CFG_SIZE_W-1:0] info_seg_reg, main_seg_reg;

    logic [15:0]   addr_reg;
    logic [15:0]   len_reg;
    logic          len_zero_reg;
    logic          region_none_reg;
    logic [15:0]   div_num_reg;
    logic [RW-1:0] div_rem_reg;
    logic [4:0]    div_cnt_reg;
    logic [SW-1:0] active_size_reg;
    logic [15:0]   seg_base_reg;
    logic [15:0]   wp_reg;
    logic [16:0]   bytes_left_reg;
    logic [SW-1:0] piece_start_reg;
    logic          active_reg;
    logic [SW-1:0] first_reg, end_reg;
    logic          last_reg;
    logic [SW-1:0] i_reg;
    logic          full_reg;
    logic          need_erase_reg;
    logic          fail_reg;
    logic          clr_last_unused;
    logic [ADDR_BITS-1:0] clr_cnt_reg;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [1:0]  out_status_reg;
    logic [7:0]  out_data_reg;

    // region decode and divider
    logic          in_info, in_main;
    logic [15:0]   region_start;
    logic [RW-1:0] div_shift;
    logic [RW-1:0] size_ext;
    assign in_info = (address >= info_low_reg) && (address <= info_high_reg);
    assign in_main = (address >= main_low_reg) && (address <= main_high_reg);
    assign region_start = in_info ? info_low_reg : main_low_reg;
    assign div_shift = {div_rem_reg[RW-2:0], div_num_reg[15]};
    assign size_ext = RW'(active_size_reg);

    // offsets and store addresses
    logic [15:0]   off16;
    logic [SW-1:0] off_sw;
    logic [SW-1:0] off_plus1;
    logic [15:0]   loc_sum;
    logic [31:0]   loc_wide;
    logic [31:0]   rd_wide;
    logic [ADDR_BITS-1:0] loc_idx;
    logic [ADDR_BITS-1:0] rd_idx;
    logic [SW-1:0] i_plus1;
    logic          outside;
    assign off16 = wp_reg - seg_base_reg;
    assign off_sw = off16[SW-1:0];
    assign off_plus1 = off_sw + SW'(1);
    assign loc_sum = seg_base_reg + 16'(i_reg);
    assign loc_wide = 32'(loc_sum);
    assign loc_idx = loc_wide[ADDR_BITS-1:0];
    assign rd_wide = 32'(address);
    assign rd_idx = rd_wide[ADDR_BITS-1:0];
    assign i_plus1 = i_reg + SW'(1);
    assign outside = (i_reg < first_reg) || (i_reg >= end_reg);

    // memories
    logic [7:0] store_rdata, buf_rdata;
    logic                 st_we;
    logic [ADDR_BITS-1:0] st_waddr;
    logic [7:0]           st_wdata;
    logic                 bf_we;
    logic [BW-1:0]        bf_waddr;
    logic [7:0]           bf_wdata;

    always_comb
    begin
        st_we = 1'b0;
        st_waddr = loc_idx;
        st_wdata = buf_rdata;
        if (cmd.clr_step)
        begin
            st_we = 1'b1;
            st_waddr = clr_cnt_reg;
            st_wdata = 8'hFF;
        end
        else if (cmd.act_rewrite)
        begin
            st_we = 1'b1;
        end
        else if (cmd.act_prog)
        begin
            st_we = 1'b1;
            st_wdata = store_rdata & buf_rdata;
        end
        bf_we = 1'b0;
        bf_waddr = i_reg[BW-1:0];
        bf_wdata = store_rdata;
        if (cmd.acc_data)
        begin
            bf_we = 1'b1;
            bf_waddr = off_sw[BW-1:0];
            bf_wdata = data_byte;
        end
        else if (cmd.act_copy && outside)
        begin
            bf_we = 1'b1;
        end
    end

    fssw_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (cmd.acc_read | cmd.mem_rd),
        .raddr (cmd.acc_read ? rd_idx : loc_idx),
        .rdata (store_rdata)
    );

    fssw_ram #(.WIDTH(8), .DEPTH(SEG_MAX)) u_segbuf (
        .clk   (clk),
        .we    (bf_we),
        .waddr (bf_waddr),
        .wdata (bf_wdata),
        .re    (cmd.mem_rd),
        .raddr (i_reg[BW-1:0]),
        .rdata (buf_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            info_low_reg <= INFO_LOW_RST;
            info_high_reg <= INFO_HIGH_RST;
            main_low_reg <= MAIN_LOW_RST;
            main_high_reg <= MAIN_HIGH_RST;
            info_seg_reg <= INFO_SEG_RST;
            main_seg_reg <= MAIN_SEG_RST;
            clr_cnt_reg <= '0;
            active_reg <= 1'b0;
            active_size_reg <= '0;
            seg_base_reg <= '0;
            wp_reg <= '0;
            bytes_left_reg <= '0;
            piece_start_reg <= '0;
            div_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INFO_LOW:  info_low_reg <= cfg_data;
                    REG_INFO_HIGH: info_high_reg <= cfg_data;
                    REG_MAIN_LOW:  main_low_reg <= cfg_data;
                    REG_MAIN_HIGH: main_high_reg <= cfg_data;
                    REG_INFO_SEG:  info_seg_reg <= cfg_data[CFG_SIZE_W-1:0];
                    REG_MAIN_SEG:  main_seg_reg <= cfg_data[CFG_SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_BITS'(1);
            end
            if (cmd.acc_start)
            begin
                active_reg <= 1'b0;
                active_size_reg <= in_info ? eff_size(info_seg_reg) : eff_size(main_seg_reg);
                div_cnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
            if (cmd.start_fin)
            begin
                seg_base_reg <= addr_reg - 16'(div_rem_reg);
                piece_start_reg <= div_rem_reg[SW-1:0];
                wp_reg <= addr_reg;
                bytes_left_reg <= {1'b0, len_reg};
                active_reg <= 1'b1;
            end
            if (cmd.acc_data)
            begin
                wp_reg <= wp_reg + 16'd1;
                bytes_left_reg <= bytes_left_reg - 17'd1;
            end
            if (cmd.next_seg)
            begin
                seg_base_reg <= seg_base_reg + 16'(active_size_reg);
                piece_start_reg <= '0;
            end
            if (cmd.clr_active)
            begin
                active_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.acc_start)
        begin
            addr_reg <= address;
            len_reg <= length;
            len_zero_reg <= (length == 16'd0);
            region_none_reg <= !in_info && !in_main;
            div_num_reg <= address - region_start;
            div_rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            div_num_reg <= {div_num_reg[14:0], 1'b0};
            div_rem_reg <= (div_shift >= size_ext) ? div_shift - size_ext : div_shift;
        end
        if (cmd.acc_data)
        begin
            first_reg <= piece_start_reg;
            end_reg <= off_plus1;
            last_reg <= (bytes_left_reg == 17'd1);
        end
        if (cmd.walk_first)
        begin
            i_reg <= first_reg;
            full_reg <= 1'b0;
            need_erase_reg <= 1'b0;
            fail_reg <= 1'b0;
        end
        else if (cmd.walk_zero)
        begin
            i_reg <= '0;
            full_reg <= 1'b1;
            fail_reg <= 1'b0;
        end
        else if (cmd.i_inc)
        begin
            i_reg <= i_plus1;
        end
        if (cmd.act_scan && ((buf_rdata & ~store_rdata) != 8'd0))
        begin
            need_erase_reg <= 1'b1;
        end
        if (cmd.act_verify && (buf_rdata != store_rdata))
        begin
            fail_reg <= 1'b1;
        end
        if (cmd.emit)
        begin
            out_kind_reg <= cmd.emit_read;
            out_status_reg <= cmd.emit_read ? ST_OK : cmd.emit_status;
            out_data_reg <= cmd.emit_read ? store_rdata : 8'd0;
        end
    end

    assign clr_last_unused = &clr_cnt_reg;

    always_comb
    begin
        stat.clr_last = clr_last_unused;
        stat.len_zero = len_zero_reg;
        stat.region_none = region_none_reg;
        stat.div_done = (div_cnt_reg == 5'd16);
        stat.write_active = active_reg;
        stat.commit_now = (bytes_left_reg == 17'd1) || (off_plus1 >= active_size_reg);
        stat.piece_last = last_reg;
        stat.i_done = full_reg ? (i_plus1 == active_size_reg) : (i_plus1 == end_reg);
        stat.need_erase = need_erase_reg;
        stat.verify_fail = fail_reg;
        stat.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign reply_kind = out_kind_reg;
    assign status = out_status_reg;
    assign read_data = out_data_reg;
endmodule
`default_nettype wire

[hdl/fssw_ctrl.sv]
// controller state machine for the flash segment writer
`default_nettype none
module fssw_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [1:0]       func,
    input  wire fssw_pkg::stat_t  stat,
    output logic                  in_ready,
    output fssw_pkg::cmd_t        cmd
);
    import fssw_pkg::*;

    localparam logic [4:0] S_CLEAR    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_RD_OUT   = 5'd2;
    localparam logic [4:0] S_CHK      = 5'd3;
    localparam logic [4:0] S_DIV      = 5'd4;
    localparam logic [4:0] S_CMT      = 5'd5;
    localparam logic [4:0] S_SCAN_RD  = 5'd6;
    localparam logic [4:0] S_SCAN_ACT = 5'd7;
    localparam logic [4:0] S_DECIDE   = 5'd8;
    localparam logic [4:0] S_COPY_RD  = 5'd9;
    localparam logic [4:0] S_COPY_ACT = 5'd10;
    localparam logic [4:0] S_REW_RD   = 5'd11;
    localparam logic [4:0] S_REW_ACT  = 5'd12;
    localparam logic [4:0] S_PROG_RD  = 5'd13;
    localparam logic [4:0] S_PROG_ACT = 5'd14;
    localparam logic [4:0] S_VER_RD   = 5'd15;
    localparam logic [4:0] S_VER_ACT  = 5'd16;
    localparam logic [4:0] S_FIN      = 5'd17;
    localparam logic [4:0] S_EMIT     = 5'd18;

    logic [4:0] state_reg, state_next;
    logic [1:0] code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            code_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg <= code_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        code_next = code_reg;
        cmd = '0;
        cmd.emit_status = code_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (func)
                        FUNC_START:
                        begin
                            cmd.acc_start = 1'b1;
                            state_next = S_CHK;
                        end
                        FUNC_DATA:
                        begin
                            if (stat.write_active)
                            begin
                                cmd.acc_data = 1'b1;
                                if (stat.commit_now)
                                    state_next = S_CMT;
                            end
                        end
                        FUNC_READ:
                        begin
                            cmd.acc_read = 1'b1;
                            state_next = S_RD_OUT;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_read = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CHK:
            begin
                if (stat.len_zero)
                begin
                    code_next = ST_ZERO_LEN;
                    state_next = S_EMIT;
                end
                else if (stat.region_none)
                begin
                    code_next = ST_NO_MEM;
                    state_next = S_EMIT;
                end
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.start_fin = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    cmd.div_step = 1'b1;
            end
            S_CMT:
            begin
                cmd.walk_first = 1'b1;
                state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_SCAN_ACT;
            end
            S_SCAN_ACT:
            begin
                cmd.act_scan = 1'b1;
                if (stat.i_done)
                    state_next = S_DECIDE;
                else
                begin
                    cmd.i_inc = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_DECIDE:
            begin
                if (stat.need_erase)
                begin
                    cmd.walk_zero = 1'b1;
                    state_next = S_COPY_RD;
                end
                else
                begin
                    cmd.walk_first = 1'b1;
                    state_next = S_PROG_RD;
                end
            end
            S_COPY_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_COPY_ACT;
            end
            S_COPY_ACT:
            begin
                cmd.act_copy = 1'b1;
                if (stat.i_done)
                begin
                    cmd.walk_zero = 1'b1;
                    state_next = S_REW_RD;
                end
                else
                begin
                    cmd.i_inc = 1'b1;
                    state_next = S_COPY_RD;
                end
            end
            S_REW_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_REW_ACT;
            end
            S_REW_ACT:
            begin
                // erase and program folded into one write per byte
                cmd.act_rewrite = 1'b1;
                if (stat.i_done)
                begin
                    cmd.walk_zero = 1'b1;
                    state_next = S_VER_RD;
                end
                else
                begin
                    cmd.i_inc = 1'b1;
                    state_next = S_REW_RD;
                end
            end
            S_PROG_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_PROG_ACT;
            end
            S_PROG_ACT:
            begin
                cmd.act_prog = 1'b1;
                if (stat.i_done)
                begin
                    cmd.walk_first = 1'b1;
                    state_next = S_VER_RD;
                end
                else
                begin
                    cmd.i_inc = 1'b1;
                    state_next = S_PROG_RD;
                end
            end
            S_VER_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_VER_ACT;
            end
            S_VER_ACT:
            begin
                cmd.act_verify = 1'b1;
                if (stat.i_done)
                    state_next = S_FIN;
                else
                begin
                    cmd.i_inc = 1'b1;
                    state_next = S_VER_RD;
                end
            end
            S_FIN:
            begin
                if (stat.verify_fail)
                begin
                    cmd.clr_active = 1'b1;
                    code_next = ST_VERIFY;
                    state_next = S_EMIT;
                end
                else if (stat.piece_last)
                begin
                    cmd.clr_active = 1'b1;
                    code_next = ST_OK;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.next_seg = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[hdl/flash_segment_smart_writer.sv]
// flash segment writer: reads answer from a registered store read, data bytes fill the buffer,
// a start item is checked and located by a bit-serial divide; a finished piece is scanned,
// then programmed and verified, or with an erase every segment byte is copied, rewritten and
// verified, each byte read and then acted on; after reset a clearing pass writes 0xFF to all
// 2**ADDR_BITS store bytes, one a cycle, with in_ready low; config writes are taken throughout
`default_nettype none
`include "flash_segment_smart_writer_defines.svh"
module flash_segment_smart_writer #(
    parameter int ADDR_BITS = fssw_pkg::ADDR_BITS_DEF,
    parameter int SEG_MAX   = fssw_pkg::SEG_MAX_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [15:0] address,
    input  wire logic [15:0] length,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             reply_kind,
    output logic [1:0]       status,
    output logic [7:0]       read_data
);
    import fssw_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fssw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    fssw_datapath #(.ADDR_BITS(ADDR_BITS), .SEG_MAX(SEG_MAX)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .address    (address),
        .length     (length),
        .data_byte  (data_byte),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .reply_kind (reply_kind),
        .status     (status),
        .read_data  (read_data)
    );

    `FSSW_ASSERT_NEXT(a_read_busy, in_valid && in_ready && (func == FUNC_READ), !in_ready)
    `FSSW_ASSERT_NEXT(a_start_busy, in_valid && in_ready && (func == FUNC_START), !in_ready)
    `FSSW_ASSERT_IMPLIES(a_read_ok, out_valid && reply_kind, status == ST_OK)
    `FSSW_ASSERT_IMPLIES(a_emit_free, cmd.emit, stat.out_free && !cmd.acc_data)
endmodule
`default_nettype wire
